/* rtl/core/heat_stencil_3d_seven_point_top_defines.svh */
// Assertion macros for the seven-point heat stencil block.
`ifndef HEAT_STENCIL_3D_SEVEN_POINT_TOP_DEFINES_SVH
`define HEAT_STENCIL_3D_SEVEN_POINT_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HS3D_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heat stencil assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HS3D_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heat stencil assertion failed");

`endif

/* rtl/core/hs3d_pkg.sv */
// Package with the widths, register indexes and stage types of the heat stencil.
`timescale 1ns / 1ps
`default_nettype none
package hs3d_pkg;
   localparam int MAX_SIDE   = 64;
   localparam int MAX_PLANES = 64;
   localparam int TEMP_W     = 32;
   localparam int POS_W      = $clog2(MAX_SIDE);
   localparam int SIZE_W     = 7;
   localparam int ADDR_W     = 1 + 2 * POS_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA         = 3'd0,
      CSR_SIDE_SIZE     = 3'd1,
      CSR_SLAB_PLANES   = 3'd2,
      CSR_SOURCE_ENABLE = 3'd3,
      CSR_SOURCE_PLANE  = 3'd4,
      CSR_SOURCE_ROW    = 3'd5,
      CSR_SOURCE_COL    = 3'd6
   } csr_index_type;

   // Control that travels alongside each cell in the pipeline.
   typedef struct packed {
      logic src;
      logic last;
   } ctl_type;
endpackage
`default_nettype wire

/* rtl/core/heat_stencil_3d_seven_point_top.sv */
// An accepted request is registered in stage 1, then in the partial sum, difference, product and output registers.
// Throughput: one cell per cycle; the five stages advance together whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Reset (synchronous, active high) clears counters and valid bits and sets configuration registers to
// their defaults; the plane store has no reset and is filled by the ghost plane.
`timescale 1ns / 1ps
`default_nettype none
`include "heat_stencil_3d_seven_point_top_defines.svh"
module heat_stencil_3d_seven_point_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [hs3d_pkg::TEMP_W-1:0]    req_temperature,
   input  wire logic                           req_sweep_start,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [hs3d_pkg::TEMP_W-1:0]         rsp_new_temperature,
   output logic                                rsp_sweep_end,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hs3d_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hs3d_pkg::CSR_DATA_W-1:0] csr_data
);
   import hs3d_pkg::*;

   // Configuration registers.
   logic [15:0]       alpha_ff;
   logic [SIZE_W-1:0] side_ff;
   logic [SIZE_W-1:0] planes_ff;
   logic              src_en_ff;
   logic [5:0]        src_plane_ff;
   logic [5:0]        src_row_ff;
   logic [5:0]        src_col_ff;

   // Stream position counters.
   logic [SIZE_W-1:0] plane_ff, plane_in;
   logic [POS_W-1:0]  row_ff, row_in;
   logic [POS_W-1:0]  col_ff, col_in;

   logic advance, accept;
   logic [SIZE_W-1:0] s_eff, p_eff, last_plane;
   logic restart;
   logic [SIZE_W-1:0] q;
   logic [POS_W-1:0]  r, c;
   logic [SIZE_W-1:0] c_inc, r_inc, q_inc;
   logic [SIZE_W-1:0] q_rel;
   logic wslot, cslot;
   logic [ADDR_W-1:0] a_write, a_tc, a_left, a_right, a_up, a_down;
   ctl_type ctl0;
   logic c_first, c_last, r_first, r_last;

   // The three copies of the plane store, each with two read ports.
   logic [TEMP_W-1:0] mem0_ff [2*MAX_SIDE*MAX_SIDE];
   logic [TEMP_W-1:0] mem1_ff [2*MAX_SIDE*MAX_SIDE];
   logic [TEMP_W-1:0] mem2_ff [2*MAX_SIDE*MAX_SIDE];
   logic [TEMP_W-1:0] above_ff, tc_rd_ff, left_rd_ff, right_rd_ff, up_rd_ff, down_rd_ff;

   // Stage 1: alongside the read data.
   logic              v1_ff;
   ctl_type           ctl1_ff;
   logic [TEMP_W-1:0] below1_ff;
   logic              cf1_ff, cl1_ff, rf1_ff, rl1_ff;
   // Stage 2: partial sums.
   logic              v2_ff;
   ctl_type           ctl2_ff;
   logic [TEMP_W-1:0] tc2_ff;
   logic [33:0]       pa2_ff, pb2_ff;
   logic [34:0]       t6_2_ff;
   // Stage 3: difference.
   logic              v3_ff;
   ctl_type           ctl3_ff;
   logic [TEMP_W-1:0] tc3_ff;
   logic signed [35:0] d3_ff;
   // Stage 4: product.
   logic              v4_ff;
   ctl_type           ctl4_ff;
   logic [TEMP_W-1:0] tc4_ff;
   logic signed [52:0] prod4_ff;
   // Output register.
   logic              rsp_valid_ff;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic              rsp_end_ff;

   logic [TEMP_W-1:0] left_v, right_v, up_v, down_v;
   logic signed [52:0] rounded;
   logic signed [37:0] total;

   // The whole pipeline moves as one when the output register can take a value.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= 16'd6554;
         side_ff      <= 7'd10;
         planes_ff    <= 7'd10;
         src_en_ff    <= 1'b1;
         src_plane_ff <= 6'd2;
         src_row_ff   <= 6'd2;
         src_col_ff   <= 6'd5;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA:         alpha_ff     <= csr_data;
            CSR_SIDE_SIZE:     side_ff      <= csr_data[SIZE_W-1:0];
            CSR_SLAB_PLANES:   planes_ff    <= csr_data[SIZE_W-1:0];
            CSR_SOURCE_ENABLE: src_en_ff    <= csr_data[0];
            CSR_SOURCE_PLANE:  src_plane_ff <= csr_data[5:0];
            CSR_SOURCE_ROW:    src_row_ff   <= csr_data[5:0];
            CSR_SOURCE_COL:    src_col_ff   <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Geometry clamped into its legal range; plane 0 is the upper ghost and
   // plane last_plane the lower ghost.
   always_comb begin
      if (side_ff < 7'd3) s_eff = 7'd3;
      else if (side_ff > SIZE_W'(MAX_SIDE)) s_eff = SIZE_W'(MAX_SIDE);
      else s_eff = side_ff;
      if (planes_ff < 7'd1) p_eff = 7'd1;
      else if (planes_ff > SIZE_W'(MAX_PLANES)) p_eff = SIZE_W'(MAX_PLANES);
      else p_eff = planes_ff;
      last_plane = p_eff + 7'd1;
   end

   // A sweep start, or counters left beyond the geometry, restart at the
   // first ghost cell before the cell is placed.
   always_comb begin
      restart = req_sweep_start || (plane_ff > last_plane)
                || ({1'b0, row_ff} >= s_eff) || ({1'b0, col_ff} >= s_eff);
      q = restart ? '0 : plane_ff;
      r = restart ? '0 : row_ff;
      c = restart ? '0 : col_ff;
      c_inc = {1'b0, c} + 7'd1;
      r_inc = {1'b0, r} + 7'd1;
      q_inc = q + 7'd1;
      col_in   = c;
      row_in   = r;
      plane_in = q;
      if (c_inc >= s_eff) begin
         col_in = '0;
         if (r_inc >= s_eff) begin
            row_in = '0;
            plane_in = (q_inc > last_plane) ? '0 : q_inc;
         end else begin
            row_in = r_inc[POS_W-1:0];
         end
      end else begin
         col_in = c_inc[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else if (accept) begin
         plane_ff <= plane_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   // Addresses: the slot of the current plane is written, the other slot holds
   // the plane whose cells are being updated. Wrapped neighbour addresses at
   // the edges are harmless since the edge flags replace them by tc.
   always_comb begin
      wslot   = q[0];
      cslot   = ~q[0];
      a_write = {wslot, r, c};
      a_tc    = {cslot, r, c};
      a_left  = {cslot, r, c - POS_W'(1)};
      a_right = {cslot, r, c + POS_W'(1)};
      a_up    = {cslot, r - POS_W'(1), c};
      a_down  = {cslot, r + POS_W'(1), c};
      c_first = (c == '0);
      c_last  = ({1'b0, c} == s_eff - 7'd1);
      r_first = (r == '0);
      r_last  = ({1'b0, r} == s_eff - 7'd1);
      q_rel   = q - 7'd2;
      ctl0.src  = src_en_ff && (q_rel == {1'b0, src_plane_ff})
                  && (r == src_row_ff) && (c == src_col_ff);
      ctl0.last = (q == last_plane) && r_last && c_last;
   end

   // Each copy reads its old contents before the incoming cell overwrites it.
   always_ff @(posedge clock) begin
      if (accept) mem0_ff[a_write] <= req_temperature;
      if (advance) begin
         above_ff <= mem0_ff[a_write];
         tc_rd_ff <= mem0_ff[a_tc];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) mem1_ff[a_write] <= req_temperature;
      if (advance) begin
         left_rd_ff  <= mem1_ff[a_left];
         right_rd_ff <= mem1_ff[a_right];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) mem2_ff[a_write] <= req_temperature;
      if (advance) begin
         up_rd_ff   <= mem2_ff[a_up];
         down_rd_ff <= mem2_ff[a_down];
      end
   end

   // Valid bits: requests of planes 0 and 1 enter as bubbles.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= accept && (q >= 7'd2);
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_comb begin
      left_v  = cf1_ff ? tc_rd_ff : left_rd_ff;
      right_v = cl1_ff ? tc_rd_ff : right_rd_ff;
      up_v    = rf1_ff ? tc_rd_ff : up_rd_ff;
      down_v  = rl1_ff ? tc_rd_ff : down_rd_ff;
      // Round to nearest with ties upward, then saturate into the unsigned range.
      rounded = prod4_ff + 53'sd32768;
      total   = $signed({6'b0, tc4_ff}) + $signed({rounded[52], rounded[52:16]});
      if (ctl4_ff.src) rsp_temp_in = tc4_ff;
      else if (total < 0) rsp_temp_in = '0;
      else if (total[37:32] != '0) rsp_temp_in = '1;
      else rsp_temp_in = total[31:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl1_ff   <= ctl0;
         below1_ff <= req_temperature;
         cf1_ff    <= c_first;
         cl1_ff    <= c_last;
         rf1_ff    <= r_first;
         rl1_ff    <= r_last;

         ctl2_ff <= ctl1_ff;
         tc2_ff  <= tc_rd_ff;
         pa2_ff  <= {2'b0, above_ff} + {2'b0, below1_ff} + {2'b0, left_v};
         pb2_ff  <= {2'b0, right_v} + {2'b0, up_v} + {2'b0, down_v};
         t6_2_ff <= {1'b0, tc_rd_ff, 2'b0} + {2'b0, tc_rd_ff, 1'b0};

         ctl3_ff <= ctl2_ff;
         tc3_ff  <= tc2_ff;
         d3_ff   <= $signed({2'b0, pa2_ff}) + $signed({2'b0, pb2_ff})
                    - $signed({1'b0, t6_2_ff});

         ctl4_ff  <= ctl3_ff;
         tc4_ff   <= tc3_ff;
         prod4_ff <= d3_ff * $signed({1'b0, alpha_ff});

         rsp_temp_ff <= rsp_temp_in;
         rsp_end_ff  <= ctl4_ff.last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_new_temperature = rsp_temp_ff;
   assign rsp_sweep_end       = rsp_end_ff;

   // A request of plane 0 or 1 never reaches the arithmetic.
   `HS3D_ASSERT_NEXT(a_ghost_bubble, clock, reset, accept && (q < 7'd2), !v1_ff)
   // A held source cell leaves with its old value untouched.
   `HS3D_ASSERT_NEXT(a_source_hold, clock, reset, advance && v4_ff && ctl4_ff.src,
                     rsp_new_temperature == $past(tc4_ff))
   // A sweep start lands on the first ghost cell and steps to its neighbour.
   `HS3D_ASSERT_NEXT(a_sweep_restart, clock, reset, accept && req_sweep_start,
                     (plane_ff == '0) && (row_ff == '0) && (col_ff == POS_W'(1)))
endmodule
`default_nettype wire
